// ===== hw/rtl/b64d_pkg.sv =====
package b64d_pkg;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Sextet offsets of the alphabet ranges
  localparam logic [5:0] OFS_LOWER = 6'd26;
  localparam logic [5:0] OFS_DIGIT = 6'd52;
  localparam logic [5:0] SEXT_PLUS  = 6'd62;
  localparam logic [5:0] SEXT_SLASH = 6'd63;

  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_HALF = 2'd1,
    PAD_DONE = 2'd2
  } pad_phase_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       is_final;
    logic       decode_ok;
  } result_item_t;

  typedef struct packed {
    logic       is_valid;
    logic [5:0] value;
  } sextet_t;

  // Map one character onto the standard alphabet
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.is_valid = 1'b1;
    s.value    = '0;
    if (ch >= "A" && ch <= "Z") begin
      s.value = 6'(ch - 8'("A"));
    end else if (ch >= "a" && ch <= "z") begin
      s.value = 6'(ch - 8'("a")) + OFS_LOWER;
    end else if (ch >= "0" && ch <= "9") begin
      s.value = 6'(ch - 8'("0")) + OFS_DIGIT;
    end else if (ch == CHAR_PLUS) begin
      s.value = SEXT_PLUS;
    end else if (ch == CHAR_SLASH) begin
      s.value = SEXT_SLASH;
    end else begin
      s.is_valid = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/b64d_unit.sv =====
module b64d_unit import b64d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  char_item_t   item,
  input  logic         advance,
  output logic         has_result,
  output result_item_t result
);

  logic [1:0] quantum_pos, quantum_pos_next;
  logic [5:0] leftover_bits, leftover_bits_next;
  pad_phase_t pad_phase, pad_phase_next;
  logic       error_seen, error_seen_next;
  logic       any_byte_out, any_byte_out_next;

  logic       skip;
  logic       have_byte;
  logic [7:0] byte_val;
  sextet_t    sx;

  assign sx   = sextet_of(item.char_code);
  assign skip = (item.char_code == CHAR_CR) || (item.char_code == CHAR_LF) ||
                (item.char_code == CHAR_SPACE) || (item.char_code == CHAR_TAB);

  // Decode one character against the current quantum state
  always_comb begin
    quantum_pos_next   = quantum_pos;
    leftover_bits_next = leftover_bits;
    pad_phase_next     = pad_phase;
    error_seen_next    = error_seen;
    any_byte_out_next  = any_byte_out;
    have_byte          = 1'b0;
    byte_val           = '0;
    if (!skip && !error_seen) begin
      if (pad_phase == PAD_DONE) begin
        error_seen_next = 1'b1;
      end else if (item.char_code == CHAR_PAD) begin
        if (quantum_pos == 2'd2 && pad_phase == PAD_NONE) begin
          pad_phase_next   = PAD_HALF;
          quantum_pos_next = 2'd3;
        end else if (quantum_pos == 2'd3) begin
          pad_phase_next   = PAD_DONE;
          quantum_pos_next = 2'd0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (!sx.is_valid || pad_phase == PAD_HALF) begin
        error_seen_next = 1'b1;
      end else begin
        unique case (quantum_pos)
          2'd0: begin
            leftover_bits_next = sx.value;
          end
          2'd1: begin
            byte_val           = {leftover_bits, sx.value[5:4]};
            leftover_bits_next = {2'b00, sx.value[3:0]};
            have_byte          = 1'b1;
          end
          2'd2: begin
            byte_val           = {leftover_bits[3:0], sx.value[5:2]};
            leftover_bits_next = {4'b0000, sx.value[1:0]};
            have_byte          = 1'b1;
          end
          default: begin
            byte_val           = {leftover_bits[1:0], sx.value};
            leftover_bits_next = '0;
            have_byte          = 1'b1;
          end
        endcase
        quantum_pos_next = quantum_pos + 2'd1;
        if (have_byte) begin
          any_byte_out_next = 1'b1;
        end
      end
    end
  end

  // Build the result beat
  always_comb begin
    has_result        = have_byte || item.last_char;
    result.byte_valid = have_byte;
    result.data_byte  = byte_val;
    result.is_final   = item.last_char;
    result.decode_ok  = item.last_char && !error_seen_next && quantum_pos_next == 2'd0 &&
                        pad_phase_next != PAD_HALF && any_byte_out_next;
  end

  // Advance the message state; clear it after the closing character
  always_ff @(posedge clk) begin
    if (rst || (advance && item.last_char)) begin
      quantum_pos   <= '0;
      leftover_bits <= '0;
      pad_phase     <= PAD_NONE;
      error_seen    <= 1'b0;
      any_byte_out  <= 1'b0;
    end else if (advance) begin
      quantum_pos   <= quantum_pos_next;
      leftover_bits <= leftover_bits_next;
      pad_phase     <= pad_phase_next;
      error_seen    <= error_seen_next;
      any_byte_out  <= any_byte_out_next;
    end
  end

endmodule

// ===== hw/rtl/strict_base64_stream_decoder.sv =====
// Strict streaming Base64 decoder.
// Character channel: char_valid / char_ready / char_data carry one character
// per beat together with a last-of-message flag. Carriage return, line feed,
// space and tab are skipped; other characters decode with the standard
// alphabet and strict '=' padding.
// Result channel: result_valid / result_ready / result_data carry one beat per
// completed byte and one beat for the closing character, which holds the
// pass/fail status (and the final byte, if any). Bytes leave before the status
// is known, so the receiver drops them when decode_ok is 0.
// Throughput: one character per cycle while result beats are taken, set by the
// single decode pass between the input register and the result register.
// Path: an accepted character is held in the input register, decoded, and
// its result beat is captured in the result register.
// Reset: clears both registers and the message state; the first character
// after reset starts a new message.
// Stall: while result_ready is low and a result is held, the input register
// still fills; once it holds a character that produces a result, char_ready
// drops until the result beat is taken.
module strict_base64_stream_decoder import b64d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_ready,
  input  char_item_t   char_data,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_data
);

  logic         in_full;
  char_item_t   in_item;
  logic         has_result;
  result_item_t unit_result;
  logic         out_free;
  logic         advance;

  assign out_free   = !result_valid || result_ready;
  assign advance    = in_full && (!has_result || out_free);
  assign char_ready = !in_full || advance;

  b64d_unit u_unit (
    .clk        (clk),
    .rst        (rst),
    .item       (in_item),
    .advance    (advance),
    .has_result (has_result),
    .result     (unit_result)
  );

  // Hold the accepted character beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      in_item <= char_data;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && has_result) begin
      result_data <= unit_result;
    end
  end

endmodule
